@@ rtl/modexp_pkg.sv @@
// Shared types and constants of the modular exponentiation block.
package modexp_pkg;

	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(WIDTH);

	typedef logic [WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_EXPONENT = 1'b0,
		REG_MODULUS  = 1'b1
	} reg_idx_t;

	// Sequencer states, one-hot
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_REDUCE = 5'b00010,
		S_SQUARE = 5'b00100,
		S_MULT   = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	// Request to the modular multiplier
	typedef struct packed {
		logic  start;
		word_t a;
		word_t b;
	} mm_req_t;

	// Response from the modular multiplier
	typedef struct packed {
		logic  done;
		word_t p;
	} mm_rsp_t;

endpackage

@@ rtl/modexp_in_if.sv @@
// Input channel: one element and its last flag.
interface modexp_in_if;
	logic                 valid;
	logic                 ready;
	modexp_pkg::word_t    message_value;
	logic                 last_in;

	modport source (output valid, output message_value, output last_in, input ready);
	modport sink   (input valid, input message_value, input last_in, output ready);
endinterface

@@ rtl/modexp_out_if.sv @@
// Output channel: one result and its last flag.
interface modexp_out_if;
	logic                 valid;
	logic                 ready;
	modexp_pkg::word_t    result_value;
	logic                 last_out;

	modport source (output valid, output result_value, output last_out, input ready);
	modport sink   (input valid, input result_value, input last_out, output ready);
endinterface

@@ rtl/modexp_mmul.sv @@
// Bit-serial modular multiplier: one shift-and-add step per cycle.
module modexp_mmul (
	input  logic                clk,
	input  logic                arst_n,
	input  modexp_pkg::word_t   modulus,
	input  modexp_pkg::mm_req_t req,
	output modexp_pkg::mm_rsp_t rsp
);

	localparam int EXT = modexp_pkg::WIDTH + 2;

	logic              busy_q;
	logic              done_q;
	modexp_pkg::cnt_t  cnt_q;
	modexp_pkg::word_t r_q;
	modexp_pkg::word_t a_q;
	modexp_pkg::word_t b_q;

	logic [EXT-1:0]    m_ext;
	logic [EXT-1:0]    dbl;
	logic [EXT-1:0]    dbl_sub;
	modexp_pkg::word_t r_dbl;
	logic [EXT-1:0]    sum;
	logic [EXT-1:0]    sum_sub;
	modexp_pkg::word_t r_next;

	// Double the partial product, then add the multiplicand where the bit is set
	always_comb begin
		m_ext   = {2'b00, modulus};
		dbl     = {1'b0, r_q, 1'b0};
		dbl_sub = dbl - m_ext;
		r_dbl   = dbl_sub[EXT-1] ? dbl[modexp_pkg::WIDTH-1:0] : dbl_sub[modexp_pkg::WIDTH-1:0];
		sum     = {2'b00, r_dbl} + (b_q[modexp_pkg::WIDTH-1] ? {2'b00, a_q} : '0);
		sum_sub = sum - m_ext;
		r_next  = sum_sub[EXT-1] ? sum[modexp_pkg::WIDTH-1:0] : sum_sub[modexp_pkg::WIDTH-1:0];
	end

	// Control: count the multiplier bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= modexp_pkg::cnt_t'(modexp_pkg::WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: load operands, then advance one bit a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= '0;
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			r_q <= r_next;
			b_q <= {b_q[modexp_pkg::WIDTH-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = r_q;

endmodule

@@ rtl/modular_exponentiation.sv @@
// Top level of the modular exponentiation block.
//
// Each accepted element is raised to the exponent register modulo the modulus
// register by left-to-right square-and-multiply; the last flag travels with it.
// All arithmetic runs on one bit-serial modular multiplier. An element first
// gets reduced by the modulus (one pass of the multiplier), then each of the
// WIDTH exponent bits costs a squaring and, where the bit is set, a further
// multiplication. With an exponent of 0 or 1 the element itself is passed on
// unchanged as the result; with a larger exponent and a modulus of 0 or 1 the
// result is 0; neither case uses the multiplier. The input is not ready while
// an element is in progress; a finished result sits in an output register, so
// a new element may be taken while the result awaits transfer.
// Write the configuration only while the block is idle.
module modular_exponentiation (
	input  logic                  clk,
	input  logic                  arst_n,
	modexp_in_if.sink             msg,
	modexp_out_if.source          res,
	input  logic                  cfg_we,
	input  modexp_pkg::reg_idx_t  cfg_index,
	input  modexp_pkg::word_t     cfg_data
);

	modexp_pkg::state_t  state_q;
	modexp_pkg::word_t   exponent_q;
	modexp_pkg::word_t   modulus_q;
	modexp_pkg::word_t   msg_q;
	modexp_pkg::word_t   base_q;
	modexp_pkg::word_t   acc_q;
	logic                last_q;
	logic                go_q;
	modexp_pkg::cnt_t    ebit_q;
	logic                res_valid_q;
	modexp_pkg::word_t   res_value_q;
	logic                res_last_q;

	modexp_pkg::mm_req_t mm_req;
	modexp_pkg::mm_rsp_t mm_rsp;
	logic                in_xfer;
	logic                out_free;

	assign in_xfer  = msg.valid && msg.ready;
	assign out_free = !res_valid_q || res.ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= modexp_pkg::word_t'(1);
			modulus_q  <= modexp_pkg::word_t'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				modexp_pkg::REG_EXPONENT: exponent_q <= cfg_data;
				modexp_pkg::REG_MODULUS:  modulus_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Select multiplier operands for the current step
	always_comb begin
		mm_req.start = go_q;
		mm_req.a     = acc_q;
		mm_req.b     = acc_q;
		unique case (state_q)
			modexp_pkg::S_REDUCE: begin
				mm_req.a = modexp_pkg::word_t'(1);
				mm_req.b = msg_q;
			end
			modexp_pkg::S_MULT: begin
				mm_req.b = base_q;
			end
			default: ;
		endcase
	end

	modexp_mmul u_mmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.modulus (modulus_q),
		.req     (mm_req),
		.rsp     (mm_rsp)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= modexp_pkg::S_IDLE;
			go_q    <= 1'b0;
			ebit_q  <= '0;
		end else begin
			go_q <= 1'b0;
			unique case (state_q)
				modexp_pkg::S_IDLE: begin
					if (in_xfer) begin
						if (exponent_q < modexp_pkg::word_t'(2) ||
						    modulus_q < modexp_pkg::word_t'(2)) begin
							state_q <= modexp_pkg::S_DONE;
						end else begin
							state_q <= modexp_pkg::S_REDUCE;
							go_q    <= 1'b1;
							ebit_q  <= modexp_pkg::cnt_t'(modexp_pkg::WIDTH - 1);
						end
					end
				end
				modexp_pkg::S_REDUCE: begin
					if (mm_rsp.done) begin
						state_q <= modexp_pkg::S_SQUARE;
						go_q    <= 1'b1;
					end
				end
				modexp_pkg::S_SQUARE: begin
					if (mm_rsp.done) begin
						if (exponent_q[ebit_q]) begin
							state_q <= modexp_pkg::S_MULT;
							go_q    <= 1'b1;
						end else if (ebit_q == '0) begin
							state_q <= modexp_pkg::S_DONE;
						end else begin
							ebit_q <= ebit_q - 1'b1;
							go_q   <= 1'b1;
						end
					end
				end
				modexp_pkg::S_MULT: begin
					if (mm_rsp.done) begin
						if (ebit_q == '0) begin
							state_q <= modexp_pkg::S_DONE;
						end else begin
							state_q <= modexp_pkg::S_SQUARE;
							ebit_q  <= ebit_q - 1'b1;
							go_q    <= 1'b1;
						end
					end
				end
				modexp_pkg::S_DONE: begin
					if (out_free) begin
						state_q <= modexp_pkg::S_IDLE;
					end
				end
				default: state_q <= modexp_pkg::S_IDLE;
			endcase
		end
	end

	// Working registers: element, reduced base and accumulator
	always_ff @(posedge clk) begin
		if (state_q == modexp_pkg::S_IDLE && in_xfer) begin
			msg_q  <= msg.message_value;
			last_q <= msg.last_in;
			if (exponent_q < modexp_pkg::word_t'(2)) begin
				acc_q <= msg.message_value;
			end else begin
				acc_q <= '0;
			end
		end else if (state_q == modexp_pkg::S_REDUCE && mm_rsp.done) begin
			base_q <= mm_rsp.p;
			acc_q  <= modexp_pkg::word_t'(1);
		end else if ((state_q == modexp_pkg::S_SQUARE || state_q == modexp_pkg::S_MULT) &&
		             mm_rsp.done) begin
			acc_q <= mm_rsp.p;
		end
	end

	// Output register: hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == modexp_pkg::S_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == modexp_pkg::S_DONE && out_free) begin
			res_value_q <= acc_q;
			res_last_q  <= last_q;
		end
	end

	assign msg.ready        = (state_q == modexp_pkg::S_IDLE);
	assign res.valid        = res_valid_q;
	assign res.result_value = res_value_q;
	assign res.last_out     = res_last_q;

	// An accepted element always leaves the idle state
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q != modexp_pkg::S_IDLE)
		else $error("sequencer stayed idle after an input transfer");

	// Products arrive only while a multiplication step is in progress
	a_done_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> (state_q == modexp_pkg::S_REDUCE ||
		                 state_q == modexp_pkg::S_SQUARE ||
		                 state_q == modexp_pkg::S_MULT))
		else $error("multiplier finished outside a multiplication step");

	// Every product is fully reduced
	a_product_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> mm_rsp.p < modulus_q)
		else $error("multiplier product not below modulus");

	// A finished element reaches a free output register at once
	a_done_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == modexp_pkg::S_DONE && !res_valid_q |=> res_valid_q)
		else $error("finished result not loaded into the output register");

endmodule
